// ===== rtl/vavg_pkg.sv =====
// Shared constants and types of the volume average restriction block.
// Holds sizes, configuration register codes and reset values; no dependencies.
package vavg_pkg;

	// Default sizing of the block.
	localparam int VAVG_MAX_NX       = 64;
	localparam int VAVG_MAX_NY       = 64;
	localparam int VAVG_MAX_NZ       = 64;
	localparam int VAVG_VALUE_WIDTH  = 32;

	// Extra sum bits: up to 2^9 fine samples add into one coarse cell.
	localparam int VAVG_SUM_GUARD    = 9;

	// Configuration port geometry.
	localparam int VAVG_CFG_INDEX_W  = 3;
	localparam int VAVG_CFG_DATA_W   = 7;
	localparam int VAVG_SIZE_W       = 7;
	localparam int VAVG_FACTOR_W     = 2;
	localparam int VAVG_DIMS_W       = 2;
	localparam int VAVG_SHIFT_W      = 4;

	// Depth of the result buffer on the coarse channel.
	localparam int VAVG_OUT_DEPTH    = 3;

	// Configuration register indexes.
	typedef enum logic [VAVG_CFG_INDEX_W-1:0] {
		CFG_LOG2_FACTOR = 3'd0,
		CFG_COARSE_NX   = 3'd1,
		CFG_COARSE_NY   = 3'd2,
		CFG_COARSE_NZ   = 3'd3,
		CFG_DIMS        = 3'd4
	} cfg_reg_t;

	// Register values after reset.
	localparam logic [VAVG_FACTOR_W-1:0] RST_LOG2_FACTOR = 2'd1;
	localparam logic [VAVG_SIZE_W-1:0]   RST_COARSE_N    = 7'd16;
	localparam logic [VAVG_DIMS_W-1:0]   RST_DIMS        = 2'd3;

endpackage

// ===== rtl/vavg_fine_if.sv =====
// Input channel of the volume average restriction block: fine samples.
// Depends on vavg_pkg for the default sample width.
interface vavg_fine_if import vavg_pkg::*; #(
	parameter int VALUE_WIDTH = VAVG_VALUE_WIDTH
);
	logic                          valid;
	logic                          ready;
	logic signed [VALUE_WIDTH-1:0] fine_value;
	logic                          frame_start;

	modport source (output valid, fine_value, frame_start, input ready);
	modport sink   (input valid, fine_value, frame_start, output ready);
endinterface

// ===== rtl/vavg_coarse_if.sv =====
// Output channel of the volume average restriction block: coarse averages.
// Depends on vavg_pkg for the default sample width.
interface vavg_coarse_if import vavg_pkg::*; #(
	parameter int VALUE_WIDTH = VAVG_VALUE_WIDTH
);
	logic                          valid;
	logic                          ready;
	logic signed [VALUE_WIDTH-1:0] coarse_value;
	logic                          coarse_last;

	modport source (output valid, coarse_value, coarse_last, input ready);
	modport sink   (input valid, coarse_value, coarse_last, output ready);
endinterface

// ===== rtl/vavg_cfg_if.sv =====
// Configuration write channel of the volume average restriction block.
// Depends on vavg_pkg for index and data widths.
interface vavg_cfg_if import vavg_pkg::*;;
	logic                        valid;
	logic                        ready;
	logic [VAVG_CFG_INDEX_W-1:0] index;
	logic [VAVG_CFG_DATA_W-1:0]  data;

	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/volume_average_restriction.sv =====
// Top level of the volume average restriction block (3-D box-filter downsample).
// Depends on vavg_pkg, the three channel interfaces and vavg_ram.
//
// Usage. Fine samples enter on the fine channel in raster order, x fastest,
// one item per cycle at most; frame_start on an item restarts the position
// counters at the origin. Each coarse cell averages r fine samples along x,
// along y too when dims is 2 or 3, and along z when dims is 3; r = 2^log2_factor.
// When the last fine sample of a cell is accepted, the average (arithmetic
// shift, rounding toward minus infinity) leaves on the coarse channel;
// coarse_last marks the final cell of the volume. A factor of zero passes
// every sample through. Registers are written on the always-ready cfg channel;
// the user must do so only while the block is idle; the block does not enforce it.
// Each result passes through the stage 1 registers into the result buffer, and is
// offered on the coarse channel from that buffer.
// Throughput: one fine item per cycle while fine.ready is high, set by the plane-sum
// RAM's read and write ports; a write and a read of the same entry on the same edge
// are resolved by forwarding the new sum.
// Results wait in a three-entry buffer. When the receiver stalls, fine.ready
// drops once the buffer plus a result still in flight would fill it.
// Reset clears the counters and the buffer and loads the register defaults;
// the RAM is not cleared, since the first sample of a cell overwrites its sum.
module volume_average_restriction import vavg_pkg::*; #(
	parameter int MAX_COARSE_NX = VAVG_MAX_NX,
	parameter int MAX_COARSE_NY = VAVG_MAX_NY,
	parameter int MAX_COARSE_NZ = VAVG_MAX_NZ
) (
	input logic          clk,
	input logic          arst_n,
	vavg_fine_if.sink    fine,
	vavg_coarse_if.source coarse,
	vavg_cfg_if.sink     cfg
);
	// Sample width is fixed by the channel interfaces.
	localparam int VALUE_WIDTH = VAVG_VALUE_WIDTH;
	// Widths derived from the sizing parameters.
	localparam int SUM_W   = VALUE_WIDTH + VAVG_SUM_GUARD;
	localparam int FX_W    = $clog2(MAX_COARSE_NX * 8 + 1);
	localparam int FY_W    = $clog2(MAX_COARSE_NY * 8 + 1);
	localparam int FZ_W    = $clog2(MAX_COARSE_NZ * 8 + 1);
	localparam int FXY_W   = (FX_W > FY_W) ? FX_W : FY_W;
	localparam int FXYZ_W  = (FXY_W > FZ_W) ? FXY_W : FZ_W;
	// Counters also hold a raw 7-bit size plus one for the clamp compares.
	localparam int CNT_W   = (FXYZ_W > VAVG_SIZE_W + 1) ? FXYZ_W : VAVG_SIZE_W + 1;
	localparam int DEPTH   = MAX_COARSE_NX * MAX_COARSE_NY;
	localparam int ADDR_W  = $clog2(DEPTH);
	localparam int PTR_W   = $clog2(VAVG_OUT_DEPTH);
	localparam int OCNT_W  = $clog2(VAVG_OUT_DEPTH + 1);

	localparam logic [CNT_W-1:0] MAX_NX_C = CNT_W'(MAX_COARSE_NX);
	localparam logic [CNT_W-1:0] MAX_NY_C = CNT_W'(MAX_COARSE_NY);
	localparam logic [CNT_W-1:0] MAX_NZ_C = CNT_W'(MAX_COARSE_NZ);
	localparam logic [CNT_W-1:0] ONE_C    = CNT_W'(1);

	// A size register of zero acts as one, and sizes are capped at the maximum.
	function automatic logic [CNT_W-1:0] clamp_size(input logic [VAVG_SIZE_W-1:0] raw,
			input logic [CNT_W-1:0] maxv);
		logic [CNT_W-1:0] ext;
		ext = CNT_W'(raw);
		if (raw == '0) begin
			return ONE_C;
		end else if (ext > maxv) begin
			return maxv;
		end
		return ext;
	endfunction

	// ------------------------------------------------------------------
	// Configuration registers.
	// ------------------------------------------------------------------
	logic [VAVG_FACTOR_W-1:0] log2_factor_q;
	logic [VAVG_SIZE_W-1:0]   coarse_nx_q;
	logic [VAVG_SIZE_W-1:0]   coarse_ny_q;
	logic [VAVG_SIZE_W-1:0]   coarse_nz_q;
	logic [VAVG_DIMS_W-1:0]   dims_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			log2_factor_q <= RST_LOG2_FACTOR;
			coarse_nx_q   <= RST_COARSE_N;
			coarse_ny_q   <= RST_COARSE_N;
			coarse_nz_q   <= RST_COARSE_N;
			dims_q        <= RST_DIMS;
		end else if (cfg.valid) begin
			// Writes to indexes beyond the register list are dropped.
			unique case (cfg_reg_t'(cfg.index))
				CFG_LOG2_FACTOR: log2_factor_q <= cfg.data[VAVG_FACTOR_W-1:0];
				CFG_COARSE_NX:   coarse_nx_q   <= cfg.data[VAVG_SIZE_W-1:0];
				CFG_COARSE_NY:   coarse_ny_q   <= cfg.data[VAVG_SIZE_W-1:0];
				CFG_COARSE_NZ:   coarse_nz_q   <= cfg.data[VAVG_SIZE_W-1:0];
				CFG_DIMS:        dims_q        <= cfg.data[VAVG_DIMS_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// ------------------------------------------------------------------
	// Effective geometry. The user is to change the registers only while the block is
	// idle (the block does not enforce it), so these are quasi-static.
	// ------------------------------------------------------------------
	logic [VAVG_DIMS_W-1:0]   dims_eff;
	logic [VAVG_FACTOR_W-1:0] sx, sy, sz;
	logic [VAVG_SHIFT_W-1:0]  shift_total;
	logic [CNT_W-1:0]         nx_c, ny_c, nz_c;
	logic [CNT_W-1:0]         fnx, fny, fnz;
	logic [CNT_W-1:0]         mask_x, mask_y, mask_z;

	always_comb begin
		dims_eff    = (dims_q == '0) ? VAVG_DIMS_W'(1) : dims_q;
		sx          = log2_factor_q;
		sy          = (dims_eff >= VAVG_DIMS_W'(2)) ? log2_factor_q : '0;
		sz          = (dims_eff == VAVG_DIMS_W'(3)) ? log2_factor_q : '0;
		shift_total = VAVG_SHIFT_W'(sx) + VAVG_SHIFT_W'(sy) + VAVG_SHIFT_W'(sz);
		nx_c        = clamp_size(coarse_nx_q, MAX_NX_C);
		ny_c        = clamp_size(coarse_ny_q, MAX_NY_C);
		nz_c        = clamp_size(coarse_nz_q, MAX_NZ_C);
		fnx         = nx_c << sx;
		fny         = ny_c << sy;
		fnz         = nz_c << sz;
		mask_x      = (ONE_C << sx) - ONE_C;
		mask_y      = (ONE_C << sy) - ONE_C;
		mask_z      = (ONE_C << sz) - ONE_C;
	end

	// ------------------------------------------------------------------
	// Stage 0: fine position, coarse cell address, RAM read.
	// ------------------------------------------------------------------
	logic [CNT_W-1:0] fine_x_q, fine_y_q, fine_z_q;
	logic [CNT_W-1:0] fx, fy, fz;
	logic [CNT_W-1:0] fx_inc, fy_inc, fz_inc;
	logic [CNT_W-1:0] cx, cy, cz;
	logic [ADDR_W-1:0] addr_s0;
	logic             first_s0, last_s0, cell_last_s0;
	logic             accept;

	// Result buffer occupancy, declared here because it gates fine.ready.
	logic [OCNT_W-1:0] ocnt_q;
	logic              valid_s1, last_s1;

	// Ready depends only on registers: the buffer must have room for the
	// result in stage 1 and for one more from the item accepted now.
	assign fine.ready = (OCNT_W'(ocnt_q) + OCNT_W'(valid_s1 && last_s1))
		< OCNT_W'(VAVG_OUT_DEPTH);
	assign accept = fine.valid && fine.ready;

	always_comb begin
		// Counters restart on frame_start, and a counter left outside the
		// current extent counts as zero.
		fx = (fine.frame_start || fine_x_q >= fnx) ? '0 : fine_x_q;
		fy = (fine.frame_start || fine_y_q >= fny) ? '0 : fine_y_q;
		fz = (fine.frame_start || fine_z_q >= fnz) ? '0 : fine_z_q;
		fx_inc = fx + ONE_C;
		fy_inc = fy + ONE_C;
		fz_inc = fz + ONE_C;

		cx = fx >> sx;
		cy = fy >> sy;
		cz = fz >> sz;
		addr_s0 = ADDR_W'(cy * MAX_NX_C + cx);

		first_s0     = ((fx & mask_x) == '0) && ((fy & mask_y) == '0)
			&& ((fz & mask_z) == '0);
		last_s0      = ((fx & mask_x) == mask_x) && ((fy & mask_y) == mask_y)
			&& ((fz & mask_z) == mask_z);
		cell_last_s0 = (cx == nx_c - ONE_C) && (cy == ny_c - ONE_C)
			&& (cz == nz_c - ONE_C);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fine_x_q <= '0;
			fine_y_q <= '0;
			fine_z_q <= '0;
		end else if (accept) begin
			if (fx_inc >= fnx) begin
				fine_x_q <= '0;
				if (fy_inc >= fny) begin
					fine_y_q <= '0;
					fine_z_q <= (fz_inc >= fnz) ? '0 : fz_inc;
				end else begin
					fine_y_q <= fy_inc;
					fine_z_q <= fz;
				end
			end else begin
				fine_x_q <= fx_inc;
				fine_y_q <= fy;
				fine_z_q <= fz;
			end
		end
	end

	// ------------------------------------------------------------------
	// Plane-sum RAM: one entry per coarse cell of a plane.
	// ------------------------------------------------------------------
	logic [SUM_W-1:0]  rdata_s1;
	logic [SUM_W-1:0]  acc_s1;
	logic [ADDR_W-1:0] addr_s1;

	vavg_ram #(
		.WIDTH (SUM_W),
		.DEPTH (DEPTH)
	) u_plane_sums (
		.clk   (clk),
		.we    (valid_s1),
		.waddr (addr_s1),
		.wdata (acc_s1),
		.re    (accept),
		.raddr (addr_s0),
		.rdata (rdata_s1)
	);

	// ------------------------------------------------------------------
	// Stage 1: accumulate, write back, form the average.
	// ------------------------------------------------------------------
	logic signed [VALUE_WIDTH-1:0] value_s1;
	logic                          first_s1, cell_last_s1, fwd_s1;
	logic [VAVG_SHIFT_W-1:0]       shift_s1;
	logic [SUM_W-1:0]              fwd_sum_q;
	logic [SUM_W-1:0]              base_s1;
	logic signed [SUM_W-1:0]       value_ext_s1;
	logic signed [SUM_W-1:0]       avg_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			value_s1     <= fine.fine_value;
			addr_s1      <= addr_s0;
			first_s1     <= first_s0;
			last_s1      <= last_s0;
			cell_last_s1 <= cell_last_s0;
			shift_s1     <= shift_total;
			// The RAM returns the old sum when stage 1 writes the same
			// entry on this edge; take the new sum from the bypass instead.
			fwd_s1       <= valid_s1 && (addr_s1 == addr_s0);
		end
		if (valid_s1) begin
			fwd_sum_q <= acc_s1;
		end
	end

	always_comb begin
		value_ext_s1 = {{VAVG_SUM_GUARD{value_s1[VALUE_WIDTH-1]}}, value_s1};
		base_s1      = fwd_s1 ? fwd_sum_q : rdata_s1;
		acc_s1       = first_s1 ? value_ext_s1 : base_s1 + value_ext_s1;
		avg_s1       = signed'(acc_s1) >>> shift_s1;
	end

	// ------------------------------------------------------------------
	// Result buffer toward the coarse channel.
	// ------------------------------------------------------------------
	logic signed [VALUE_WIDTH-1:0] obuf_value_q [VAVG_OUT_DEPTH];
	logic                          obuf_last_q  [VAVG_OUT_DEPTH];
	logic [PTR_W-1:0]              wr_ptr_q, rd_ptr_q;
	logic                          push, pop;

	assign push = valid_s1 && last_s1;
	assign pop  = coarse.valid && coarse.ready;

	assign coarse.valid        = (ocnt_q != '0);
	assign coarse.coarse_value = obuf_value_q[rd_ptr_q];
	assign coarse.coarse_last  = obuf_last_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			ocnt_q   <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(VAVG_OUT_DEPTH - 1)) ? '0
					: wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(VAVG_OUT_DEPTH - 1)) ? '0
					: rd_ptr_q + PTR_W'(1);
			end
			ocnt_q <= ocnt_q + OCNT_W'(push) - OCNT_W'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			obuf_value_q[wr_ptr_q] <= avg_s1[VALUE_WIDTH-1:0];
			obuf_last_q[wr_ptr_q]  <= cell_last_s1;
		end
	end

endmodule

// ===== rtl/vavg_ram.sv =====
// Generic single write port, single read port RAM with a registered read.
// A read at the address written on the same edge returns the old contents.
module vavg_ram #(
	parameter int WIDTH = 41,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end
endmodule

// ===== tb/volume_average_restriction_tb.sv =====
// Self-checking testbench for volume_average_restriction: fine samples in, coarse averages out.
// Depends on vavg_pkg, the fine, coarse and cfg channel interfaces and the block itself.
// A scoreboard class predicts every coarse item and checks the block's results against it.
module volume_average_restriction_tb;
	import vavg_pkg::*;

	localparam int VALUE_W = VAVG_VALUE_WIDTH;
	localparam int SUM_W = VAVG_VALUE_WIDTH + VAVG_SUM_GUARD;

	// A result passes the stage 1 registers and the result buffer before it shows, and the
	// last writes of the plane-sum RAM settle during the drain wait as well.
	localparam int DRAIN_CYCLES = 4;
	localparam int END_CYCLES = 8;

	// The receiver holds off this long once, so that the result buffer fills and
	// the block has to stall its fine channel.
	localparam int HOLD_CYCLES = 80;

	// The longest quiet stretch of a correct run comes from the hold above; this limit lies well beyond it.
	localparam int QUIET_LIMIT = 2000;

	localparam int RANDOM_ITEMS = 700;
	localparam int RANDOM_RESULTS = 48;

	typedef enum int {
		IDLE_NONE,
		IDLE_SENDER,
		IDLE_RECEIVER,
		IDLE_BOTH
	} idle_mode_t;

	typedef struct {
		logic signed [VALUE_W-1:0] coarse_value;
		logic                      coarse_last;
	} cell_average_t;

	// Predicts the coarse averages from the accepted fine items and checks the
	// block's results against them, oldest first.
	class coarse_scoreboard;
		logic [VAVG_FACTOR_W-1:0] log2_factor;
		logic [VAVG_SIZE_W-1:0]   coarse_nx;
		logic [VAVG_SIZE_W-1:0]   coarse_ny;
		logic [VAVG_SIZE_W-1:0]   coarse_nz;
		logic [VAVG_DIMS_W-1:0]   dims;
		int unsigned              fine_pos [3];
		bit signed [SUM_W-1:0]    plane_sums [VAVG_MAX_NX*VAVG_MAX_NY];
		cell_average_t            pending_averages [$];
		int                       errors;
		int                       predicted;

		function new();
			log2_factor = RST_LOG2_FACTOR;
			coarse_nx = RST_COARSE_N;
			coarse_ny = RST_COARSE_N;
			coarse_nz = RST_COARSE_N;
			dims = RST_DIMS;
		endfunction

		function void set_register(cfg_reg_t reg_idx, logic [VAVG_CFG_DATA_W-1:0] value);
			case (reg_idx)
				CFG_LOG2_FACTOR: log2_factor = value[VAVG_FACTOR_W-1:0];
				CFG_COARSE_NX:   coarse_nx = value;
				CFG_COARSE_NY:   coarse_ny = value;
				CFG_COARSE_NZ:   coarse_nz = value;
				CFG_DIMS:        dims = value[VAVG_DIMS_W-1:0];
				default: ;
			endcase
		endfunction

		// Sizes of 0 act as 1 and sizes above the maximum act as the maximum.
		function int unsigned clamp_size(int unsigned size, int unsigned max_size);
			if (size == 0)
				return 1;
			return (size > max_size) ? max_size : size;
		endfunction

		// Per axis: the shift that maps a fine position to its cell, and the
		// number of coarse cells. Axes beyond dims are not refined.
		function void geometry(output int unsigned shift [3], output int unsigned extent [3]);
			int unsigned d;
			d = (dims == 0) ? 1 : dims;
			for (int a = 0; a < 3; a++)
				shift[a] = (d > a) ? log2_factor : 0;
			extent[0] = clamp_size(coarse_nx, VAVG_MAX_NX);
			extent[1] = clamp_size(coarse_ny, VAVG_MAX_NY);
			extent[2] = clamp_size(coarse_nz, VAVG_MAX_NZ);
		endfunction

		function int unsigned volume_items();
			int unsigned shift [3], extent [3], total;
			geometry(shift, extent);
			total = 1;
			for (int a = 0; a < 3; a++)
				total *= extent[a] << shift[a];
			return total;
		endfunction

		function void absorb_fine(logic signed [VALUE_W-1:0] value, logic frame_start);
			int unsigned shift [3], extent [3], cell_idx [3], offs [3];
			int unsigned slot;
			bit at_first, at_last;
			logic signed [SUM_W-1:0] acc, avg;
			cell_average_t cell_avg;
			geometry(shift, extent);
			if (frame_start) begin
				fine_pos = '{0, 0, 0};
			end
			at_first = 1'b1;
			at_last = 1'b1;
			for (int a = 0; a < 3; a++) begin
				// A position left beyond the extent by a size change restarts at zero.
				if (fine_pos[a] >= (extent[a] << shift[a])) begin
					fine_pos[a] = 0;
				end
				cell_idx[a] = fine_pos[a] >> shift[a];
				offs[a] = fine_pos[a] & ((1 << shift[a]) - 1);
				at_first &= (offs[a] == 0);
				at_last &= (offs[a] == (1 << shift[a]) - 1);
			end
			slot = cell_idx[1] * VAVG_MAX_NX + cell_idx[0];
			if (at_first) begin
				acc = value;
			end else begin
				acc = plane_sums[slot] + value;
			end
			plane_sums[slot] = acc;
			if (at_last) begin
				avg = acc >>> (shift[0] + shift[1] + shift[2]);
				cell_avg.coarse_value = avg[VALUE_W-1:0];
				cell_avg.coarse_last = (cell_idx[0] == extent[0] - 1) &&
					(cell_idx[1] == extent[1] - 1) && (cell_idx[2] == extent[2] - 1);
				pending_averages.push_back(cell_avg);
				predicted++;
			end
			// Raster advance, x fastest; the volume wraps to the origin at its end.
			for (int a = 0; a < 3; a++) begin
				fine_pos[a]++;
				if (fine_pos[a] < (extent[a] << shift[a]))
					break;
				fine_pos[a] = 0;
			end
		endfunction

		function void check_coarse(logic signed [VALUE_W-1:0] value, logic last);
			cell_average_t want;
			if (pending_averages.size() == 0) begin
				$error("unexpected coarse item: coarse_value %0d, coarse_last %0b", value, last);
				errors++;
				return;
			end
			want = pending_averages.pop_front();
			if (value !== want.coarse_value) begin
				$error("coarse_value mismatch: expected %0d, actual %0d",
					want.coarse_value, value);
				errors++;
			end
			if (last !== want.coarse_last) begin
				$error("coarse_last mismatch: expected %0b, actual %0b",
					want.coarse_last, last);
				errors++;
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;

	vavg_fine_if   fine ();
	vavg_coarse_if coarse ();
	vavg_cfg_if    cfg ();

	coarse_scoreboard sb;

	// Idling percentages, changed by the stimulus between phases and read every cycle.
	int send_idle_pct;
	int recv_stall_pct;

	// Set by the stimulus to ask the receiver for its long hold-off, taken once.
	bit hold_request;

	volume_average_restriction i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.fine   (fine),
		.coarse (coarse),
		.cfg    (cfg)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	task automatic set_idling(input idle_mode_t mode);
		case (mode)
			IDLE_NONE: begin
				send_idle_pct = 0;
				recv_stall_pct = 0;
			end
			IDLE_SENDER: begin
				send_idle_pct = 70;
				recv_stall_pct = 0;
			end
			IDLE_RECEIVER: begin
				send_idle_pct = 0;
				recv_stall_pct = 70;
			end
			default: begin
				send_idle_pct = 35;
				recv_stall_pct = 35;
			end
		endcase
	endtask

	// Offers one fine item, after random idle cycles, and returns at the edge that
	// accepts it. Valid stays high so that the next item can follow back to back.
	task automatic send_fine(input logic signed [VALUE_W-1:0] value, input logic start);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			fine.valid <= 1'b0;
			@(posedge clk);
		end
		fine.valid <= 1'b1;
		fine.fine_value <= value;
		fine.frame_start <= start;
		@(posedge clk);
		while (!fine.ready)
			@(posedge clk);
		sb.absorb_fine(value, start);
	endtask

	task automatic put_register(input cfg_reg_t reg_idx, input logic [VAVG_CFG_DATA_W-1:0] value);
		cfg.valid <= 1'b1;
		cfg.index <= reg_idx;
		cfg.data <= value;
		@(posedge clk);
		while (!cfg.ready)
			@(posedge clk);
		sb.set_register(reg_idx, value);
	endtask

	// Writes all five registers; the raw bits go to the block, so upper bits of the
	// factor and dims words are exercised too.
	task automatic write_registers(input logic [6:0] factor_bits, input logic [6:0] nx,
			input logic [6:0] ny, input logic [6:0] nz, input logic [6:0] dims_bits);
		put_register(CFG_LOG2_FACTOR, factor_bits);
		put_register(CFG_COARSE_NX, nx);
		put_register(CFG_COARSE_NY, ny);
		put_register(CFG_COARSE_NZ, nz);
		put_register(CFG_DIMS, dims_bits);
		cfg.valid <= 1'b0;
	endtask

	// Stops offering items, waits for every predicted average, then lets the last
	// items that cause no result finish their sum updates.
	task automatic wait_drained();
		fine.valid <= 1'b0;
		while (sb.pending_averages.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	function automatic logic signed [VALUE_W-1:0] rand_value();
		case ($urandom_range(0, 11))
			0: return {1'b1, {(VALUE_W-1){1'b0}}};
			1: return {1'b0, {(VALUE_W-1){1'b1}}};
			2: return '1;
			3: return '0;
			default: return VALUE_W'($urandom);
		endcase
	endfunction

	// Mostly small sizes keep volumes short; zero, the maximum and values above the
	// maximum show up now and then to exercise the clamping.
	function automatic logic [6:0] pick_size();
		case ($urandom_range(0, 19))
			0: return 7'd0;
			1: return 7'd64;
			2: return 7'($urandom_range(65, 127));
			default: return 7'($urandom_range(1, 4));
		endcase
	endfunction

	// One random phase: a fresh setting, then a volume (or part of one) of random
	// samples. The first item opens the volume whenever sums are accumulated, so no
	// sum entry is ever added into before the first sample of its cell wrote it.
	// A stray frame_start now and then restarts the volume mid-stream.
	task automatic random_phase(output int unsigned count);
		int unsigned factor, dim_sel, volume;
		logic start;
		factor = $urandom_range(0, 3);
		dim_sel = $urandom_range(0, 3);
		write_registers({5'($urandom_range(0, 31)), 2'(factor)}, pick_size(), pick_size(),
			pick_size(), {5'($urandom_range(0, 31)), 2'(dim_sel)});
		volume = sb.volume_items();
		if (volume <= 160 || (volume <= 512 && $urandom_range(0, 2) == 0)) begin
			// Whole volume plus a few items past its end, which wrap to the origin.
			count = volume + $urandom_range(0, 3);
		end else begin
			count = $urandom_range(24, 160);
		end
		for (int i = 0; i < count; i++) begin
			start = ($urandom_range(0, 29) == 0);
			if (i == 0 && (factor != 0 || $urandom_range(0, 1) == 1)) begin
				start = 1'b1;
			end
			send_fine(rand_value(), start);
		end
		wait_drained();
	endtask

	// Receiver: checks each accepted coarse item and drives ready, with random
	// stalls and, once on request, a long hold-off.
	initial begin : receiver
		int hold_left;
		bit hold_taken;
		hold_left = 0;
		hold_taken = 1'b0;
		coarse.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (coarse.valid && coarse.ready) begin
				sb.check_coarse(coarse.coarse_value, coarse.coarse_last);
			end
			if (hold_request && !hold_taken) begin
				hold_taken = 1'b1;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				coarse.ready <= 1'b0;
			end else begin
				coarse.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
			end
		end
	end

	// Watchdog: the run is hung if no channel moves an item for too long.
	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if ((fine.valid && fine.ready) || (coarse.valid && coarse.ready) ||
					(cfg.valid && cfg.ready)) begin
				quiet = 0;
			end else begin
				quiet++;
			end
		end
		$display("volume_average_restriction_tb failed");
		$finish;
	end

	initial begin : stimulus
		int unsigned random_items, results_before, phase, count;
		sb = new();
		arst_n <= 1'b0;
		fine.valid <= 1'b0;
		fine.fine_value <= '0;
		fine.frame_start <= 1'b0;
		cfg.valid <= 1'b0;
		cfg.index <= CFG_LOG2_FACTOR;
		cfg.data <= '0;
		hold_request = 1'b0;
		set_idling(IDLE_NONE);
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset setting (factor 2, 16 cells per axis, three dimensions): two extreme
		// samples open a cell but complete none, so no result is due.
		send_fine({1'b0, {(VALUE_W-1){1'b1}}}, 1'b1);
		send_fine({1'b1, {(VALUE_W-1){1'b0}}}, 1'b0);
		wait_drained();

		// Pass-through with a zero factor hidden under set upper bits, a zero row
		// size that acts as one, and zero dims that act as one. Every sample is the
		// last cell of a one-cell volume.
		write_registers(7'h7C, 7'd0, 7'd1, 7'd1, 7'h7C);
		send_fine({1'b1, {(VALUE_W-1){1'b0}}}, 1'b0);
		send_fine({1'b0, {(VALUE_W-1){1'b1}}}, 1'b0);
		send_fine('0, 1'b0);
		send_fine('1, 1'b1);
		wait_drained();

		// Shrinking the row in the middle of a volume leaves the x position beyond
		// the new extent, so the next sample lands at x zero.
		write_registers(7'h7C, 7'd3, 7'd1, 7'd1, 7'd1);
		send_fine(rand_value(), 1'b1);
		send_fine(rand_value(), 1'b0);
		wait_drained();
		write_registers(7'h7C, 7'd1, 7'd1, 7'd1, 7'd1);
		send_fine(rand_value(), 1'b0);
		wait_drained();

		// Factor 2 along x only: two maximal samples average to the maximum, and the
		// two most negative ones round down to the minimum.
		write_registers(7'h7D, 7'd2, 7'd1, 7'd1, 7'd1);
		send_fine({1'b0, {(VALUE_W-1){1'b1}}}, 1'b1);
		send_fine({1'b0, {(VALUE_W-1){1'b1}}}, 1'b0);
		send_fine({1'b1, {(VALUE_W-1){1'b0}}}, 1'b0);
		send_fine({1'b1, {(VALUE_W-1){1'b0}}} + 1, 1'b0);
		wait_drained();

		// Factor 2 in two dimensions with a plane count above the maximum: a sum of
		// minus three over four cells must round toward minus infinity.
		write_registers(7'd1, 7'd1, 7'd1, 7'd127, 7'd2);
		send_fine('1, 1'b1);
		send_fine('1, 1'b0);
		send_fine('1, 1'b0);
		send_fine('0, 1'b0);
		wait_drained();

		// Back pressure: the receiver holds off while samples stream through, so the
		// result buffer fills and the fine channel must stall.
		write_registers(7'd0, 7'd4, 7'd4, 7'd4, 7'd1);
		hold_request = 1'b1;
		for (int i = 0; i < 40; i++)
			send_fine(rand_value(), i == 0);
		wait_drained();

		// Random phases with rotating idling modes, until enough items and results.
		random_items = 0;
		results_before = sb.predicted;
		phase = 0;
		while (random_items < RANDOM_ITEMS || sb.predicted - results_before < RANDOM_RESULTS) begin
			set_idling(idle_mode_t'(phase % 4));
			random_phase(count);
			random_items += count;
			phase++;
		end

		wait_drained();
		repeat (END_CYCLES) @(posedge clk);
		if (sb.errors == 0 && sb.pending_averages.size() == 0) begin
			$display("volume_average_restriction_tb passed");
		end else begin
			$display("volume_average_restriction_tb failed");
		end
		$finish;
	end

endmodule
